// File: src/tst_pkg.sv
// Package for the timer slot table: operation, status and state codes.
// Used by the slot table core and its checker; depends on nothing else.
package tst_pkg;

   // Operation codes carried on the request channel.
   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_TICK   = 2'd1,
      FUNC_CANCEL = 2'd2
   } func_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_DUP  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // Sequencer states of the core.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Slot index reported when no slot applies.
   localparam logic [2:0] NO_SLOT     = 3'd7;
   // Most expiries reported per tick, and the cancel count ceiling.
   localparam logic [2:0] MAX_REPORTS = 3'd7;
   localparam logic [2:0] COUNT_MAX   = 3'd7;

endpackage

// File: src/tst_slot_mem.sv
// Slot memory of the timer slot table: time left, action and reason per slot.
// Synchronous read, registered on the clock edge; never-written slots read as zero.
// Depends on nothing else.
module tst_slot_mem #(
   parameter int SLOT_COUNT = 7,
   parameter int TIME_WIDTH = 16,
   parameter int IW         = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [IW-1:0]         rd_addr,
   input  logic                  wr_en,
   input  logic [IW-1:0]         wr_addr,
   input  logic [TIME_WIDTH-1:0] wr_time,
   input  logic [7:0]            wr_action,
   input  logic [7:0]            wr_reason,
   output logic [TIME_WIDTH-1:0] rd_time,
   output logic [7:0]            rd_action,
   output logic [7:0]            rd_reason
);

   logic [TIME_WIDTH-1:0] time_mem_ff   [SLOT_COUNT];
   logic [7:0]            action_mem_ff [SLOT_COUNT];
   logic [7:0]            reason_mem_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] written_ff;

   logic [TIME_WIDTH-1:0] rd_time_ff;
   logic [7:0]            rd_action_ff;
   logic [7:0]            rd_reason_ff;
   logic                  rd_live_ff;

   // Per-slot written flags stand in for clearing the memory at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem_ff[wr_addr]   <= wr_time;
         action_mem_ff[wr_addr] <= wr_action;
         reason_mem_ff[wr_addr] <= wr_reason;
      end
   end

   // Registered read port; data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_time_ff   <= time_mem_ff[rd_addr];
         rd_action_ff <= action_mem_ff[rd_addr];
         rd_reason_ff <= reason_mem_ff[rd_addr];
         rd_live_ff   <= written_ff[rd_addr];
      end
   end

   // A slot that was never written reads as its reset value of zero.
   assign rd_time   = rd_live_ff ? rd_time_ff   : '0;
   assign rd_action = rd_live_ff ? rd_action_ff : 8'd0;
   assign rd_reason = rd_live_ff ? rd_reason_ff : 8'd0;

endmodule

// File: src/timer_slot_table_core.sv
// Timer slot table core: a table of countdown slots with add, tick and cancel.
// Depends on tst_pkg and on the slot memory tst_slot_mem.
//
// Usage:
// A request transaction (req_*) carries one operation. An add places a timer
// in the first free slot unless a busy slot ahead of it has the same reason;
// a tick decrements every busy slot and reports each expiry in slot order; a
// cancel frees every slot with the given reason. Each request produces one or
// more response transactions (rsp_*); rsp_last marks the final one.
// One request is handled at a time. The sequencer walks the slot memory one
// slot per cycle while the output register can take its response, reading a
// slot and writing it back in the write-back stage; a cancel walks every slot,
// a tick gives its closing response after the walk, and an add stops at the
// slot that decides it. A new request can be taken once the final response is loaded.
// A paused tick or an unused operation code skips the walk and gives only the closing response.
// The response sits in an output register; when the receiver stalls, the
// walk holds at the slot that needs to report and resumes once the register
// frees up. Reset returns the sequencer to idle and marks every slot free
// with zero action and reason; it needs no clearing pass.
module timer_slot_table_core
   import tst_pkg::*;
#(
   parameter int SLOT_COUNT = 7,
   parameter int TIME_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_duration,
   input  logic [7:0]  req_action_code,
   input  logic [7:0]  req_reason_code,
   input  logic        req_paused,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_fired,
   output logic [7:0]  rsp_fired_action,
   output logic [2:0]  rsp_slot_index,
   output logic [2:0]  rsp_cancelled_count,
   output logic        rsp_last
);

   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam logic [IW-1:0] LAST_SLOT  = IW'(SLOT_COUNT - 1);
   localparam logic [CW-1:0] SLOT_TOTAL = CW'(SLOT_COUNT);

   state_type state_ff, state_in;

   // Latched request.
   logic [1:0]            func_ff;
   logic [TIME_WIDTH-1:0] dur_ff;
   logic [7:0]            act_ff;
   logic [7:0]            rsn_ff;

   // Walk control.
   logic [CW-1:0] rd_cnt_ff, rd_cnt_in;
   logic          pv_ff, pv_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic [2:0]    fires_ff, fires_in;
   logic [2:0]    ccnt_ff, ccnt_in;

   // Held expiry, sent once the next one or the end of the walk is known.
   logic       hold_v_ff, hold_v_in;
   logic [7:0] hold_act_ff, hold_act_in;
   logic [2:0] hold_idx_ff, hold_idx_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff;
   logic       rsp_fired_ff;
   logic [7:0] rsp_action_ff;
   logic [2:0] rsp_slot_ff;
   logic [2:0] rsp_count_ff;
   logic       rsp_last_ff;

   // Response being loaded this cycle.
   logic       out_load;
   logic [1:0] out_status;
   logic       out_fired;
   logic [7:0] out_action;
   logic [2:0] out_slot;
   logic [2:0] out_count;
   logic       out_last;
   logic       out_free;

   // Memory access.
   logic                  rd_en;
   logic [IW-1:0]         rd_addr;
   logic                  wr_en;
   logic [TIME_WIDTH-1:0] wr_time;
   logic [7:0]            wr_action;
   logic [7:0]            wr_reason;
   logic [TIME_WIDTH-1:0] rd_time;
   logic [7:0]            rd_action;
   logic [7:0]            rd_reason;

   // Per-slot decode.
   logic                  req_accept;
   logic [TIME_WIDTH+15:0] dur_wide;
   logic [IW+2:0]         pidx_wide;
   logic [2:0]            pidx3;
   logic                  busy;
   logic                  rsn_hit;
   logic                  last_slot;
   logic                  fire;
   logic [TIME_WIDTH-1:0] time_dec;
   logic [2:0]            ccnt_next;
   logic                  emit_req;
   logic                  finish;
   logic                  consume;
   logic                  advance;

   tst_slot_mem #(
      .SLOT_COUNT (SLOT_COUNT),
      .TIME_WIDTH (TIME_WIDTH),
      .IW         (IW)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (pidx_ff),
      .wr_time   (wr_time),
      .wr_action (wr_action),
      .wr_reason (wr_reason),
      .rd_time   (rd_time),
      .rd_action (rd_action),
      .rd_reason (rd_reason)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Duration is cut or extended to the slot time width.
   assign dur_wide  = {{TIME_WIDTH{1'b0}}, req_duration};
   assign pidx_wide = {3'b000, pidx_ff};
   assign pidx3     = pidx_wide[2:0];

   // Decode of the slot in the write-back stage.
   assign busy      = (rd_time != '0);
   assign rsn_hit   = (rd_reason == rsn_ff);
   assign last_slot = (pidx_ff == LAST_SLOT);
   assign time_dec  = rd_time - TIME_WIDTH'(1);
   assign fire      = busy && (rd_time == TIME_WIDTH'(1)) && (fires_ff != MAX_REPORTS);
   assign ccnt_next = (busy && rsn_hit && (ccnt_ff != COUNT_MAX)) ? ccnt_ff + 3'd1 : ccnt_ff;

   // Next state, memory access and response selection.
   always_comb begin
      state_in    = state_ff;
      rd_cnt_in   = rd_cnt_ff;
      pv_in       = pv_ff;
      pidx_in     = pidx_ff;
      fires_in    = fires_ff;
      ccnt_in     = ccnt_ff;
      hold_v_in   = hold_v_ff;
      hold_act_in = hold_act_ff;
      hold_idx_in = hold_idx_ff;
      rd_en       = 1'b0;
      rd_addr     = rd_cnt_ff[IW-1:0];
      wr_en       = 1'b0;
      wr_time     = time_dec;
      wr_action   = rd_action;
      wr_reason   = rd_reason;
      emit_req    = 1'b0;
      finish      = 1'b0;
      consume     = 1'b0;
      advance     = 1'b0;
      out_load    = 1'b0;
      out_status  = STATUS_DONE;
      out_fired   = 1'b0;
      out_action  = 8'd0;
      out_slot    = NO_SLOT;
      out_count   = 3'd0;
      out_last    = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rd_cnt_in = '0;
               pv_in     = 1'b0;
               fires_in  = 3'd0;
               ccnt_in   = 3'd0;
               hold_v_in = 1'b0;
               if (req_func == FUNC_ADD || req_func == FUNC_CANCEL ||
                   (req_func == FUNC_TICK && !req_paused)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_SCAN: begin
            // Decide what the slot in write-back needs.
            if (pv_ff) begin
               case (func_ff)
                  FUNC_ADD: begin
                     if (!busy) begin
                        emit_req = 1'b1;
                        finish   = 1'b1;
                        out_slot = pidx3;
                     end else if (rsn_hit) begin
                        emit_req   = 1'b1;
                        finish     = 1'b1;
                        out_status = STATUS_DUP;
                     end else if (last_slot) begin
                        emit_req   = 1'b1;
                        finish     = 1'b1;
                        out_status = STATUS_FULL;
                     end
                  end
                  FUNC_TICK: begin
                     if (fire && hold_v_ff) begin
                        emit_req   = 1'b1;
                        out_fired  = 1'b1;
                        out_action = hold_act_ff;
                        out_slot   = hold_idx_ff;
                        out_last   = 1'b0;
                     end
                  end
                  FUNC_CANCEL: begin
                     if (last_slot) begin
                        emit_req  = 1'b1;
                        finish    = 1'b1;
                        out_count = ccnt_next;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
               consume = !emit_req || out_free;
            end

            // Write back the slot and update the walk.
            if (consume) begin
               out_load = emit_req;
               case (func_ff)
                  FUNC_ADD: begin
                     if (!busy) begin
                        wr_en     = 1'b1;
                        wr_time   = dur_ff;
                        wr_action = act_ff;
                        wr_reason = rsn_ff;
                     end
                  end
                  FUNC_TICK: begin
                     wr_en = busy;
                     if (fire) begin
                        hold_v_in   = 1'b1;
                        hold_act_in = rd_action;
                        hold_idx_in = pidx3;
                        fires_in    = fires_ff + 3'd1;
                     end
                     if (last_slot) begin
                        state_in = ST_DONE;
                     end
                  end
                  FUNC_CANCEL: begin
                     wr_en   = rsn_hit;
                     wr_time = '0;
                     ccnt_in = ccnt_next;
                  end
                  default: begin
                     wr_en = 1'b0;
                  end
               endcase
               if (finish) begin
                  state_in = ST_IDLE;
               end
            end

            // Issue the next slot read.
            advance = (!pv_ff || consume) && !(consume && finish) &&
                      (rd_cnt_ff != SLOT_TOTAL);
            if (advance) begin
               rd_en     = 1'b1;
               pidx_in   = rd_cnt_ff[IW-1:0];
               rd_cnt_in = rd_cnt_ff + CW'(1);
            end
            pv_in = advance || (pv_ff && !consume);
         end

         ST_DONE: begin
            // Closing response: the held expiry, or a plain completion.
            out_fired  = hold_v_ff;
            out_action = hold_v_ff ? hold_act_ff : 8'd0;
            out_slot   = hold_v_ff ? hold_idx_ff : NO_SLOT;
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pv_ff        <= 1'b0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_cnt_ff    <= '0;
         fires_ff     <= 3'd0;
         ccnt_ff      <= 3'd0;
      end else begin
         state_ff     <= state_in;
         pv_ff        <= pv_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_cnt_ff    <= rd_cnt_in;
         fires_ff     <= fires_in;
         ccnt_ff      <= ccnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pidx_ff     <= pidx_in;
      hold_act_ff <= hold_act_in;
      hold_idx_ff <= hold_idx_in;
      if (req_accept) begin
         func_ff <= req_func;
         dur_ff  <= dur_wide[TIME_WIDTH-1:0];
         act_ff  <= req_action_code;
         rsn_ff  <= req_reason_code;
      end
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_fired_ff  <= out_fired;
         rsp_action_ff <= out_action;
         rsp_slot_ff   <= out_slot;
         rsp_count_ff  <= out_count;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_fired           = rsp_fired_ff;
   assign rsp_fired_action    = rsp_action_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_cancelled_count = rsp_count_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// File: src/tst_checker.sv
// Port-level checker for the timer slot table core, bound to the core module.
// Depends on tst_pkg for the status codes.
module tst_checker
   import tst_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_func,
   input logic [15:0] req_duration,
   input logic [7:0]  req_action_code,
   input logic [7:0]  req_reason_code,
   input logic        req_paused,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic        rsp_fired,
   input logic [7:0]  rsp_fired_action,
   input logic [2:0]  rsp_slot_index,
   input logic [2:0]  rsp_cancelled_count,
   input logic        rsp_last
);

   // A stalled response transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_fired) && $stable(rsp_fired_action) && $stable(rsp_slot_index) &&
      $stable(rsp_cancelled_count) && $stable(rsp_last))
      else $error("response changed while stalled");

   // Only one request is in work at a time.
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // A response that reports no expiry carries no action.
   a_no_fire_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_fired_action == 8'd0)
      else $error("action reported without an expiry");

   // Duplicate and full results are single, final and report no expiry.
   a_refuse_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DONE |->
      rsp_last && !rsp_fired && rsp_slot_index == NO_SLOT)
      else $error("refused add reported badly");

   // A cancel count only appears on a final result with no slot.
   a_cancel_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cancelled_count != 3'd0 |->
      rsp_last && !rsp_fired && rsp_slot_index == NO_SLOT)
      else $error("cancel count on a wrong result");

endmodule

bind timer_slot_table_core tst_checker u_tst_checker (.*);
